### hdl/dnsesc_pkg.sv
// ----------------------------------------------------------------------------
// DNS name escape decoder package
// Shared constants, escape modes and the result bundle passed from the
// decoder to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dnsesc_pkg;

  localparam int unsigned MAX_CAPACITY = 4096;
  localparam int unsigned CAP_W        = 13;
  localparam int unsigned CAP_RESET    = 256;
  localparam int unsigned RES_MAX      = 3;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_NUL       = 8'h00;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_ONE  = 2'd2,
    MODE_TWO  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]          num;
    result_t [RES_MAX-1:0] res;
  } push_t;

endpackage

`default_nettype wire

### hdl/dns_name_escape_decoder_core.sv
// Timing: the results of an accepted request are registered in the result queue.
// Throughput: one request per cycle while each yields at most one result and the
//   output is not stalled; results leave one per cycle unless stalled, so a request
//   with two or three results stalls the input until the queue drains to one entry.
// Reset: synchronous, active high; escape state idle, counts zero, capacity 256.
// ----------------------------------------------------------------------------
// DNS name escape decoder
// Decodes presentation-format escapes in a name, one byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_name_escape_decoder_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [7:0]                   char_byte,
  input  wire logic                         end_of_name,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [7:0]                        out_byte,
  output logic                              is_terminator,
  output logic                              last_of_run,
  input  wire logic                         cfg_we,
  input  wire logic [dnsesc_pkg::CAP_W-1:0] cfg_wdata
);

  dnsesc_pkg::push_t   push;
  dnsesc_pkg::result_t head;
  logic                full;
  logic                accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  dnsesc_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_byte   (char_byte),
    .end_of_name (end_of_name),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .push        (push)
  );

  dnsesc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte      = head.data;
  assign is_terminator = head.term;
  assign last_of_run   = head.last;

endmodule

`default_nettype wire

### hdl/dnsesc_decode.sv
// ----------------------------------------------------------------------------
// DNS name escape decoder - step logic
// Holds the escape state, emitted byte count and capacity register; turns
// one accepted request into up to three results combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsesc_decode (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         accept,
  input  wire logic [7:0]                   char_byte,
  input  wire logic                         end_of_name,
  input  wire logic                         cfg_we,
  input  wire logic [dnsesc_pkg::CAP_W-1:0] cfg_wdata,
  output dnsesc_pkg::push_t                 push
);

  dnsesc_pkg::mode_t              mode, mode_next;
  logic [3:0]                     first_digit, first_next;
  logic [3:0]                     second_digit, second_next;
  logic [dnsesc_pkg::CAP_W-1:0]   bytes_emitted, bytes_emitted_next;
  logic [dnsesc_pkg::CAP_W-1:0]   out_capacity;

  logic [dnsesc_pkg::CAP_W-1:0]   cap;
  logic                           is_end, is_bs, is_dig;
  logic [3:0]                     dig_val;
  logic [7:0]                     first_char, second_char;
  logic [10:0]                    esc_val;
  logic [1:0]                     ncand;
  logic [7:0]                     cand [dnsesc_pkg::RES_MAX];
  logic                           term;
  logic [dnsesc_pkg::CAP_W:0]     cap_ext;
  logic                           ok0, ok1, ok2;
  logic [1:0]                     allowed;
  logic [1:0]                     total;

  assign cap = (out_capacity > dnsesc_pkg::CAP_W'(dnsesc_pkg::MAX_CAPACITY))
             ? dnsesc_pkg::CAP_W'(dnsesc_pkg::MAX_CAPACITY) : out_capacity;
  assign cap_ext = {1'b0, cap};

  assign is_end      = end_of_name || (char_byte == dnsesc_pkg::CHAR_NUL);
  assign is_bs       = (char_byte == dnsesc_pkg::CHAR_BACKSLASH);
  assign is_dig      = (char_byte >= dnsesc_pkg::CHAR_ZERO) &&
                       (char_byte <= dnsesc_pkg::CHAR_NINE);
  assign dig_val     = 4'(char_byte - dnsesc_pkg::CHAR_ZERO);
  assign first_char  = dnsesc_pkg::CHAR_ZERO + {4'b0, first_digit};
  assign second_char = dnsesc_pkg::CHAR_ZERO + {4'b0, second_digit};
  assign esc_val     = 11'(first_digit) * 11'd100 + 11'(second_digit) * 11'd10
                     + 11'(dig_val);

  assign ok0 = ({1'b0, bytes_emitted} + 14'd1) < cap_ext;
  assign ok1 = ({1'b0, bytes_emitted} + 14'd2) < cap_ext;
  assign ok2 = ({1'b0, bytes_emitted} + 14'd3) < cap_ext;

  always_comb begin
    mode_next   = mode;
    first_next  = first_digit;
    second_next = second_digit;
    ncand       = 2'd0;
    cand[0]     = char_byte;
    cand[1]     = char_byte;
    cand[2]     = char_byte;
    term        = 1'b0;
    if (is_end) begin
      mode_next   = dnsesc_pkg::MODE_IDLE;
      first_next  = 4'd0;
      second_next = 4'd0;
      term        = (cap != '0);
      cand[0]     = first_char;
      cand[1]     = second_char;
      case (mode)
        dnsesc_pkg::MODE_ONE: ncand = 2'd1;
        dnsesc_pkg::MODE_TWO: ncand = 2'd2;
        default:              ncand = 2'd0;
      endcase
    end else begin
      case (mode)
        dnsesc_pkg::MODE_IDLE: begin
          if (is_bs) begin
            mode_next = dnsesc_pkg::MODE_ESC;
          end else begin
            ncand = 2'd1;
          end
        end
        dnsesc_pkg::MODE_ESC: begin
          if (is_dig) begin
            first_next = dig_val;
            mode_next  = dnsesc_pkg::MODE_ONE;
          end else begin
            mode_next = dnsesc_pkg::MODE_IDLE;
            ncand     = 2'd1;
          end
        end
        dnsesc_pkg::MODE_ONE: begin
          if (is_dig) begin
            second_next = dig_val;
            mode_next   = dnsesc_pkg::MODE_TWO;
          end else begin
            cand[0] = first_char;
            if (is_bs) begin
              ncand     = 2'd1;
              mode_next = dnsesc_pkg::MODE_ESC;
            end else begin
              ncand     = 2'd2;
              mode_next = dnsesc_pkg::MODE_IDLE;
            end
          end
        end
        dnsesc_pkg::MODE_TWO: begin
          mode_next = dnsesc_pkg::MODE_IDLE;
          if (is_dig) begin
            ncand   = 2'd1;
            cand[0] = esc_val[7:0];
          end else begin
            cand[0] = first_char;
            cand[1] = second_char;
            if (is_bs) begin
              ncand     = 2'd2;
              mode_next = dnsesc_pkg::MODE_ESC;
            end else begin
              ncand = 2'd3;
            end
          end
        end
        default: mode_next = dnsesc_pkg::MODE_IDLE;
      endcase
    end
  end

  assign allowed = 2'({1'b0, (ncand >= 2'd1) && ok0}) +
                   2'({1'b0, (ncand >= 2'd2) && ok1}) +
                   2'({1'b0, (ncand == 2'd3) && ok2});
  assign total   = allowed + 2'({1'b0, term});

  assign bytes_emitted_next = is_end ? '0 : bytes_emitted + dnsesc_pkg::CAP_W'(allowed);

  always_comb begin
    for (int i = 0; i < dnsesc_pkg::RES_MAX; i++) begin
      push.res[i].data = 8'd0;
      push.res[i].term = 1'b0;
      if (2'(i) < allowed) begin
        push.res[i].data = cand[i];
      end else if (term && (2'(i) == allowed)) begin
        push.res[i].term = 1'b1;
      end
      push.res[i].last = (2'(i + 1) == total);
    end
    push.num = accept ? total : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= dnsesc_pkg::MODE_IDLE;
      first_digit   <= 4'd0;
      second_digit  <= 4'd0;
      bytes_emitted <= '0;
      out_capacity  <= dnsesc_pkg::CAP_W'(dnsesc_pkg::CAP_RESET);
    end else begin
      if (accept) begin
        mode          <= mode_next;
        first_digit   <= first_next;
        second_digit  <= second_next;
        bytes_emitted <= bytes_emitted_next;
      end
      if (cfg_we) begin
        out_capacity <= cfg_wdata;
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && is_end) |=> (mode == dnsesc_pkg::MODE_IDLE && bytes_emitted == '0))
    else $error("escape state not cleared after end of name");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_emitted < dnsesc_pkg::CAP_W'(dnsesc_pkg::MAX_CAPACITY))
    else $error("emitted byte count out of range");

  a_zero_cap_silent: assert property (@(posedge clk) disable iff (rst)
    (cap == '0) |-> (push.num == 2'd0))
    else $error("result produced with zero capacity");

endmodule

`default_nettype wire

### hdl/dnsesc_queue.sv
// ----------------------------------------------------------------------------
// DNS name escape decoder - result queue
// Four-entry queue that takes up to three results a cycle while not full and
// presents one result a cycle on the output channel while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dnsesc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  dnsesc_pkg::push_t      push,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dnsesc_pkg::result_t    head
);

  dnsesc_pkg::result_t ent [dnsesc_pkg::QUEUE_DEPTH];
  logic [1:0]          wr_ptr, rd_ptr;
  logic [2:0]          count, count_next;
  logic                pop;

  assign out_valid  = (count != 3'd0);
  assign pop        = out_valid && !out_stall;
  assign full       = (count > 3'd1);
  assign head       = ent[rd_ptr];
  assign count_next = count + 3'(push.num) - 3'({2'b0, pop});

  always_ff @(posedge clk) begin
    for (int i = 0; i < dnsesc_pkg::RES_MAX; i++) begin
      if (2'(i) < push.num) begin
        ent[wr_ptr + 2'(i)] <= push.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.num;
      rd_ptr <= rd_ptr + 2'({1'b0, pop});
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(dnsesc_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.num != 2'd0) |-> (count <= 3'd1))
    else $error("results pushed without room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && push.num == 2'd0) |=> (count == $past(count) - 3'd1))
    else $error("queue count did not drop after a pop");

endmodule

`default_nettype wire
